// ===== rtl/srcb_pkg.sv =====
package srcb_pkg;

    // Field widths
    localparam int POS_W      = 12;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CH_N       = PIX_W / CH_W;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Divider steps per pipeline stage and resulting stage counts
    localparam int MOD_STEPS  = 2;
    localparam int MOD_STG    = POS_W / MOD_STEPS;
    localparam int FRAC_STEPS = 2;
    localparam int FRAC_STG   = FRAC_W / FRAC_STEPS;

    // Register reset values
    localparam logic [POS_W-1:0] STRIPE_WIDTH_RST = 12'd10;
    localparam logic             ALONG_ROWS_RST   = 1'b1;
    localparam logic             FORWARD_DIR_RST  = 1'b1;
    localparam logic [PIX_W-1:0] WORK_COLOR_RST   = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIPE_WIDTH = 2'd0,
        CFG_ALONG_ROWS   = 2'd1,
        CFG_FORWARD_DIR  = 2'd2,
        CFG_WORK_COLOR   = 2'd3
    } cfg_idx_t;

    // Beat in flight through the position modulo divider
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             rising;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rem;
    } mod_item_t;

    // Beat in flight through the fraction divider
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [POS_W-1:0]  rem;
        logic [FRAC_W-1:0] quo;
    } frac_item_t;

    // Beat handed to the blend stages
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [FRAC_W-1:0] factor;
    } blend_item_t;

    // One restoring step of pos mod w: shift in the next dividend bit
    function automatic logic [POS_W-1:0] mod_step(logic [POS_W-1:0] rem, logic din,
                                                  logic [POS_W-1:0] w);
        logic [POS_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, w})
        begin
            t = t - {1'b0, w};
        end
        return t[POS_W-1:0];
    endfunction

    // One fraction bit of rem / w, with rem below w
    function automatic frac_item_t frac_step(frac_item_t it, logic [POS_W-1:0] w);
        logic [POS_W:0] t;
        frac_item_t     o;
        o     = it;
        t     = {it.rem, 1'b0};
        o.quo = {it.quo[FRAC_W-2:0], 1'b0};
        if (t >= {1'b0, w})
        begin
            t        = t - {1'b0, w};
            o.quo[0] = 1'b1;
        end
        o.rem = t[POS_W-1:0];
        return o;
    endfunction

endpackage

// ===== rtl/srcb_mod_unit.sv =====
module srcb_mod_unit
    import srcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] width,
    input  logic             in_valid,
    output logic             in_ready,
    input  mod_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output mod_item_t        out_item
);

    logic [MOD_STG-1:0] valid_reg;
    logic [MOD_STG-1:0] stg_en;
    mod_item_t          item_reg  [MOD_STG];
    mod_item_t          item_next [MOD_STG];

    // A stage loads when empty or when the stage after it moves
    always_comb
    begin
        stg_en[MOD_STG-1] = !valid_reg[MOD_STG-1] || out_ready;
        for (int k = MOD_STG - 2; k >= 0; k--)
        begin
            stg_en[k] = !valid_reg[k] || stg_en[k+1];
        end
    end

    assign in_ready  = stg_en[0];
    assign out_valid = valid_reg[MOD_STG-1];
    assign out_item  = item_reg[MOD_STG-1];

    for (genvar k = 0; k < MOD_STG; k++)
    begin : g_stage
        mod_item_t src;
        logic      src_valid;

        if (k == 0)
        begin : g_first
            assign src       = in_item;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src       = item_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        // Shift the dividend bits into the remainder, a few per stage
        always_comb
        begin
            item_next[k] = src;
            for (int s = 0; s < MOD_STEPS; s++)
            begin
                item_next[k].rem = mod_step(item_next[k].rem, item_next[k].pos[POS_W-1],
                                            width);
                item_next[k].pos = {item_next[k].pos[POS_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stg_en[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[k])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

endmodule

// ===== rtl/srcb_frac_unit.sv =====
module srcb_frac_unit
    import srcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] width,
    input  logic             in_valid,
    output logic             in_ready,
    input  mod_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output blend_item_t      out_item
);

    localparam int NSTG = FRAC_STG + 1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stg_en;
    frac_item_t      item_reg  [NSTG];
    frac_item_t      item_next [NSTG];

    always_comb
    begin
        stg_en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_en[k] = !valid_reg[k] || stg_en[k+1];
        end
    end

    assign in_ready        = stg_en[0];
    assign out_valid       = valid_reg[NSTG-1];
    assign out_item.pixel  = item_reg[NSTG-1].pixel;
    assign out_item.factor = item_reg[NSTG-1].quo;

    // Entry stage: flip the ramp for the falling direction
    always_comb
    begin
        item_next[0].pixel = in_item.pixel;
        item_next[0].quo   = '0;
        item_next[0].rem   = in_item.rising ? in_item.rem
                                            : width - POS_W'(1) - in_item.rem;
    end

    for (genvar k = 1; k < NSTG; k++)
    begin : g_stage
        // Develop fraction bits of rem / width, force zero for zero width
        always_comb
        begin
            item_next[k] = item_reg[k-1];
            for (int s = 0; s < FRAC_STEPS; s++)
            begin
                item_next[k] = frac_step(item_next[k], width);
            end
            if ((k == NSTG - 1) && (width == '0))
            begin
                item_next[k].quo = '0;
            end
        end
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_reg
        logic src_valid;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stg_en[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[k])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

endmodule

// ===== rtl/srcb_blend.sv =====
module srcb_blend
    import srcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PIX_W-1:0] color,
    input  logic             in_valid,
    output logic             in_ready,
    input  blend_item_t      in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    logic [2*CH_W-1:0] prod_src_reg  [CH_N];
    logic [2*CH_W:0]   prod_col_reg  [CH_N];
    logic [2*CH_W-1:0] prod_src_next [CH_N];
    logic [2*CH_W:0]   prod_col_next [CH_N];
    logic [PIX_W-1:0]  pixel_reg;
    logic [PIX_W-1:0]  pixel_next;
    logic              mul_valid_reg;
    logic              out_valid_reg;
    logic              mul_en;
    logic              out_en;
    logic [CH_W:0]     inv_factor;

    assign out_en    = !out_valid_reg || out_ready;
    assign mul_en    = !mul_valid_reg || out_en;
    assign in_ready  = mul_en;
    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;

    // Form both products of each channel
    assign inv_factor = (CH_W+1)'(256) - {1'b0, in_item.factor};

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            prod_src_next[c] = {{CH_W{1'b0}}, in_item.pixel[c*CH_W +: CH_W]}
                             * {{CH_W{1'b0}}, in_item.factor};
            prod_col_next[c] = {{(CH_W+1){1'b0}}, color[c*CH_W +: CH_W]}
                             * {{CH_W{1'b0}}, inv_factor};
        end
    end

    // Sum the products and drop the low byte
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            pixel_next[c*CH_W +: CH_W] = 8'(({1'b0, prod_src_reg[c]} + prod_col_reg[c]) >> CH_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_en)
            begin
                mul_valid_reg <= in_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_src_reg <= prod_src_next;
            prod_col_reg <= prod_col_next;
        end
        if (out_en)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

// ===== rtl/stripe_ramp_color_blend.sv =====
// Pipeline of 6 modulo divider stages, 5 fraction divider stages and 2 blend stages.
// Throughput: one beat per cycle; each stage holds its beat while stalled and
// bubbles close up, so input is taken while a finished pixel waits.
// Reset (rst_n low, asynchronous): pipeline empties, registers take
// width 10, row mode, forward direction, black work color.
module stripe_ramp_color_blend
    import srcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // pixel_in[23:0], pos_x[35:24], pos_y[47:36]
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata   // pixel_out[23:0]
);

    logic [POS_W-1:0] stripe_width_reg;
    logic             along_rows_reg;
    logic             forward_dir_reg;
    logic [PIX_W-1:0] work_color_reg;

    mod_item_t        mod_in;
    mod_item_t        mod_out;
    logic             mod_out_valid;
    logic             frac_in_ready;
    blend_item_t      frac_out;
    logic             frac_out_valid;
    logic             blend_in_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_width_reg <= STRIPE_WIDTH_RST;
            along_rows_reg   <= ALONG_ROWS_RST;
            forward_dir_reg  <= FORWARD_DIR_RST;
            work_color_reg   <= WORK_COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STRIPE_WIDTH: stripe_width_reg <= cfg_data[POS_W-1:0];
                CFG_ALONG_ROWS:   along_rows_reg   <= cfg_data[0];
                CFG_FORWARD_DIR:  forward_dir_reg  <= cfg_data[0];
                CFG_WORK_COLOR:   work_color_reg   <= cfg_data[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pick the ramp coordinate; column mode reads the direction flag inverted
    always_comb
    begin
        mod_in.pixel  = s_axis_tdata[23:0];
        mod_in.pos    = along_rows_reg ? s_axis_tdata[47:36] : s_axis_tdata[35:24];
        mod_in.rising = along_rows_reg ? forward_dir_reg : !forward_dir_reg;
        mod_in.rem    = '0;
    end

    srcb_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (stripe_width_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (mod_in),
        .out_valid (mod_out_valid),
        .out_ready (frac_in_ready),
        .out_item  (mod_out)
    );

    srcb_frac_unit u_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (stripe_width_reg),
        .in_valid  (mod_out_valid),
        .in_ready  (frac_in_ready),
        .in_item   (mod_out),
        .out_valid (frac_out_valid),
        .out_ready (blend_in_ready),
        .out_item  (frac_out)
    );

    srcb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .color     (work_color_reg),
        .in_valid  (frac_out_valid),
        .in_ready  (blend_in_ready),
        .in_item   (frac_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata)
    );

    // An empty or draining output stage lets the whole pipe move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output stage can move");

    // Zero or unit width gives a flat factor of zero: output is the work color
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (stripe_width_reg <= POS_W'(1))) |-> (m_axis_tdata == work_color_reg))
        else $error("flat ramp did not yield the work color");

endmodule

// ===== sim/stripe_blend_checker.sv =====
module stripe_blend_checker
    import srcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // pixel_in[23:0], pos_x[35:24], pos_y[47:36]
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [PIX_W-1:0]      m_axis_tdata,  // pixel_out[23:0]
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the block's registers
    logic [POS_W-1:0] width_q;
    logic             rows_q;
    logic             fwd_q;
    logic [PIX_W-1:0] color_q;

    // Blended pixels still owed by the block, oldest first
    logic [PIX_W-1:0] blend_due[$];

    logic in_beat;
    logic out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Sawtooth factor and per-channel mix toward the work color
    function automatic logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] pix,
                                                     logic [POS_W-1:0] px,
                                                     logic [POS_W-1:0] py);
        int unsigned      pos;
        int unsigned      w;
        int unsigned      r;
        int unsigned      f;
        int unsigned      src;
        int unsigned      col;
        logic             rise;
        logic [PIX_W-1:0] res;
        w    = 32'(width_q);
        pos  = rows_q ? 32'(py) : 32'(px);
        // column mode flips the sense of the direction flag
        rise = rows_q ? fwd_q : !fwd_q;
        f    = 0;
        if (w != 0)
        begin
            r = pos % w;
            if (!rise)
            begin
                r = w - 1 - r;
            end
            f = (r * 256) / w;
        end
        res = '0;
        for (int c = 0; c < CH_N; c++)
        begin
            src = 32'(pix[c*CH_W +: CH_W]);
            col = 32'(color_q[c*CH_W +: CH_W]);
            res[c*CH_W +: CH_W] = CH_W'((src * f + col * (256 - f)) / 256);
        end
        return res;
    endfunction

    // Predict on input beats, compare on output beats, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        logic [PIX_W-1:0] want;
        if (!rst_n)
        begin
            width_q <= STRIPE_WIDTH_RST;
            rows_q  <= ALONG_ROWS_RST;
            fwd_q   <= FORWARD_DIR_RST;
            color_q <= WORK_COLOR_RST;
            errors  <= 0;
            pending <= 0;
            blend_due.delete();
        end
        else
        begin
            if (in_beat)
            begin
                blend_due.push_back(blend_pixel(s_axis_tdata[23:0], s_axis_tdata[35:24],
                                                s_axis_tdata[47:36]));
            end
            if (out_beat)
            begin
                if (blend_due.size() == 0)
                begin
                    $display("%0t: pixel_out expected none got %06h", $time, m_axis_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = blend_due.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: pixel_out expected %06h got %06h", $time, want,
                                 m_axis_tdata);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= blend_due.size();
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STRIPE_WIDTH: width_q <= cfg_data[POS_W-1:0];
                    CFG_ALONG_ROWS:   rows_q  <= cfg_data[0];
                    CFG_FORWARD_DIR:  fwd_q   <= cfg_data[0];
                    CFG_WORK_COLOR:   color_q <= cfg_data[PIX_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top
    import srcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_PHASES  = 20;
    localparam int PHASE_BEATS  = 80;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_STRIPE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata  = '0;  // pixel_in[23:0], pos_x[35:24], pos_y[47:36]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;        // pixel_out[23:0]

    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   sink_hold   = 0;
    logic calm        = 1'b0;

    stripe_ramp_color_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stripe_blend_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random backpressure on the output side
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25)
            begin
                sink_hold <= pick_gap();
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one pixel beat after a random gap and hold until taken
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic [POS_W-1:0] px,
                              logic [POS_W-1:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px, pix};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Wait until every owed pixel has come out
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stop input, drain, then write all four registers on back-to-back cycles
    task automatic apply_config(logic [POS_W-1:0] w, logic rows, logic fwd,
                                logic [PIX_W-1:0] color);
        logic [CFG_DATA_W-1:0] vals[4];
        cfg_idx_t              idx[4];
        s_axis_tvalid <= 1'b0;
        drain();
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(rows), CFG_DATA_W'(fwd), color};
        idx  = '{CFG_STRIPE_WIDTH, CFG_ALONG_ROWS, CFG_FORWARD_DIR, CFG_WORK_COLOR};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return '1;
        end
        return PIX_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return '1;
        end
        return POS_W'($urandom_range(0, 4095));
    endfunction

    // One phase of random settings and random or raster-ordered pixels
    task automatic random_phase(int beats, logic pause_mid);
        logic [POS_W-1:0] w;
        logic [PIX_W-1:0] color;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic             raster;
        int               pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       w = '0;
            1:       w = 12'd1;
            2:       w = '1;
            3, 4, 5: w = POS_W'($urandom_range(2, 16));
            default: w = POS_W'($urandom_range(1, 4095));
        endcase
        pick = $urandom_range(0, 7);
        color = (pick == 0) ? '0 : (pick == 1) ? '1 : PIX_W'($urandom);
        apply_config(w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), color);
        raster = 1'($urandom_range(0, 1));
        cx     = rand_pos();
        cy     = rand_pos();
        for (int i = 0; i < beats; i++)
        begin
            // hold off input once until the pipeline is empty
            if (pause_mid && i == beats / 2)
            begin
                s_axis_tvalid <= 1'b0;
                drain();
            end
            if (raster)
            begin
                send_pixel(rand_pixel(), cx, cy);
                cx = cx + 1'b1;
                if (cx == 0)
                begin
                    cy = cy + 1'b1;
                end
            end
            else
            begin
                send_pixel(rand_pixel(), rand_pos(), rand_pos());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: width ten, row ramp, black
        send_pixel(24'hffffff, 12'd0, 12'd0);
        send_pixel(24'hffffff, 12'd4095, 12'd5);
        send_pixel(24'h80ff01, 12'd17, 12'd9);

        // zero width gives the work color
        apply_config(12'd0, 1'b1, 1'b1, 24'ha5c3e7);
        send_pixel(24'h000000, 12'd3, 12'd4095);
        send_pixel(24'hffffff, 12'd4095, 12'd0);

        // width of one, both modes, falling ramp in each
        apply_config(12'd1, 1'b1, 1'b0, 24'hffffff);
        send_pixel(24'h123456, 12'd0, 12'd7);
        send_pixel(24'h000000, 12'd1, 12'd4095);
        apply_config(12'd1, 1'b0, 1'b1, 24'h123456);
        send_pixel(24'hfedcba, 12'd4095, 12'd1);

        // widest stripe in column mode, rising then falling
        apply_config(12'd4095, 1'b0, 1'b0, 24'hff0000);
        send_pixel(24'h00ffff, 12'd0, 12'd0);
        send_pixel(24'h00ffff, 12'd4094, 12'd100);
        send_pixel(24'h00ffff, 12'd4095, 12'd4095);
        apply_config(12'd4095, 1'b0, 1'b1, 24'h00ff00);
        send_pixel(24'hff00ff, 12'd0, 12'd4095);
        send_pixel(24'hff00ff, 12'd4095, 12'd0);

        // widest stripe in row mode, falling
        apply_config(12'd4095, 1'b1, 1'b0, 24'h0000ff);
        send_pixel(24'hffff00, 12'd2048, 12'd0);
        send_pixel(24'hffff00, 12'd0, 12'd4095);

        // extreme pixel against extreme color
        apply_config(12'd7, 1'b0, 1'b1, 24'hffffff);
        send_pixel(24'h000000, 12'd6, 12'd0);
        send_pixel(24'h000000, 12'd4095, 12'd4095);
        apply_config(12'd3, 1'b1, 1'b1, 24'h000000);
        send_pixel(24'hffffff, 12'd0, 12'd4095);
        send_pixel(24'hffffff, 12'd4095, 12'd2);

        // random settings, some phases without any idling
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            calm = (p % 4 == 3);
            random_phase(PHASE_BEATS, p == 6);
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srcb_pkg.sv
rtl/srcb_mod_unit.sv
rtl/srcb_frac_unit.sv
rtl/srcb_blend.sv
rtl/stripe_ramp_color_blend.sv
sim/stripe_blend_checker.sv
sim/tb_top.sv
